[hw/rtl/isc_pkg.sv]
`default_nettype none

package isc_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int COUNT_WIDTH = 9;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic [COUNT_WIDTH-1:0]       comparisons;
        logic                         overflow;
        logic                         final_res;
    } res_t;

    typedef struct packed {
        logic                         insert;
        logic                         shift;
        logic signed [DATA_WIDTH-1:0] value;
    } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/isc_cell.sv]
`default_nettype none

module isc_cell (
    input  wire                                   clk,
    input  wire isc_pkg::cell_ctl_t               ctl,
    input  wire                                   occupied,
    input  wire                                   at_tail,
    input  wire                                   lower_gt,
    input  wire logic signed [isc_pkg::DATA_WIDTH-1:0] lower_val,
    input  wire logic signed [isc_pkg::DATA_WIDTH-1:0] upper_val,
    output logic signed [isc_pkg::DATA_WIDTH-1:0] val,
    output logic                                  gt,
    output logic                                  recv
);

    logic signed [isc_pkg::DATA_WIDTH-1:0] val_reg;
    logic signed [isc_pkg::DATA_WIDTH-1:0] val_next;
    logic                                  take;

    assign gt   = occupied && (val_reg > ctl.value);
    assign take = gt || at_tail;
    assign recv = take && !lower_gt;
    assign val  = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctl.insert && take)
        begin
            val_next = lower_gt ? lower_val : ctl.value;
        end
        else if (ctl.shift)
        begin
            val_next = upper_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

[hw/rtl/insertion_sorter_with_comparison_count.sv]
`default_nettype none

// Streaming insertion sorter. Each request carries one signed element; a row
// of CAPACITY cells compares every held value with it at once and shifts the
// larger ones up, so elements are taken one per cycle outside emission. The
// element flagged last triggers emission: the row shifts toward cell 0 once
// per result, holding while res_stall keeps a valid result waiting, and
// no request is taken until the final result has been loaded into the
// output register. Every result carries the array's comparison total, which
// counts, per insertion, the held values larger than the new one plus one if
// some held value is not larger, saturating at 511. Elements that arrive with
// CAPACITY values held are dropped and mark overflow on all results.

module insertion_sorter_with_comparison_count #(
    parameter int CAPACITY = 32
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_stall,
    input  wire isc_pkg::req_t req,
    output logic               res_valid,
    input  wire                res_stall,
    output isc_pkg::res_t      res
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CW    = isc_pkg::COUNT_WIDTH;

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_EMIT = 1'b1;

    logic [0:0]       state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [OCC_W-1:0] rem_reg, rem_next;
    logic [CW-1:0]    total_reg, total_next;
    logic             drop_reg, drop_next;
    logic             res_valid_reg, res_valid_next;
    isc_pkg::res_t    res_reg, res_next;

    isc_pkg::cell_ctl_t ctl;
    logic signed [isc_pkg::DATA_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0] cell_gt;
    logic [CAPACITY-1:0] cell_recv;

    logic             accept;
    logic             full;
    logic             can_load;
    logic             emit_load;
    logic [OCC_W-1:0] pos;
    logic [OCC_W-1:0] added;
    logic [CW:0]      sum;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign full      = (occ_reg == OCC_W'(CAPACITY));
    assign can_load  = !res_valid_reg || !res_stall;
    assign emit_load = (state_reg == ST_EMIT) && can_load;

    assign ctl.insert = accept && !full;
    assign ctl.shift  = emit_load;
    assign ctl.value  = req.value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            isc_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .occupied (OCC_W'(gi) < occ_reg),
                .at_tail  (OCC_W'(gi) == occ_reg),
                .lower_gt ((gi == 0) ? 1'b0 : cell_gt[(gi == 0) ? 0 : gi - 1]),
                .lower_val(cell_val[(gi == 0) ? 0 : gi - 1]),
                .upper_val(cell_val[(gi == CAPACITY - 1) ? gi : gi + 1]),
                .val      (cell_val[gi]),
                .gt       (cell_gt[gi]),
                .recv     (cell_recv[gi])
            );
        end
    endgenerate

    always_comb
    begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_recv[i])
            begin
                pos = pos | OCC_W'(i);
            end
        end
    end

    assign added = (occ_reg - pos) + OCC_W'(pos != '0);
    assign sum   = {1'b0, total_reg} + (CW + 1)'(added);

    always_comb
    begin
        state_next     = state_reg;
        occ_next       = occ_reg;
        rem_next       = rem_reg;
        total_next     = total_reg;
        drop_next      = drop_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        occ_next   = occ_reg + 1'b1;
                        total_next = sum[CW] ? isc_pkg::COUNT_MAX : sum[CW-1:0];
                    end
                    if (req.last)
                    begin
                        state_next = ST_EMIT;
                        rem_next   = full ? occ_reg : occ_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = ST_IDLE;
                    occ_next   = '0;
                    total_next = '0;
                    drop_next  = 1'b0;
                end
                else if (can_load)
                begin
                    res_valid_next        = 1'b1;
                    res_next.sorted_value = cell_val[0];
                    res_next.comparisons  = total_reg;
                    res_next.overflow     = drop_reg;
                    res_next.final_res    = (rem_reg == OCC_W'(1));
                    rem_next              = rem_reg - 1'b1;
                    if (rem_reg == OCC_W'(1))
                    begin
                        state_next = ST_IDLE;
                        occ_next   = '0;
                        total_next = '0;
                        drop_next  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            rem_reg       <= '0;
            total_reg     <= '0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rem_reg       <= rem_next;
            total_reg     <= total_next;
            drop_reg      <= drop_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rem_reg != '0) && (rem_reg <= occ_reg))
        else $error("emission count out of range");

    a_one_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |-> $onehot(cell_recv))
        else $error("insertion slot not unique");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && rem_reg == OCC_W'(1)) |=>
            (state_reg == ST_IDLE) && (occ_reg == '0) && (total_reg == '0)
            && res_valid && res.final_res)
        else $error("final result did not clear the sorter");

endmodule

`default_nettype wire

[dv/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = isc_pkg::DATA_WIDTH;
    localparam int CW = isc_pkg::COUNT_WIDTH;
    localparam int CAPACITY = 32;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 105;

    typedef struct {
        isc_pkg::req_t payload;
        bit            drain_first;
    } array_elem_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    isc_pkg::req_t req = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    isc_pkg::res_t res;

    array_elem_t array_elems[$];
    isc_pkg::res_t expected_sorted[$];

    logic signed [DW-1:0] held_values[CAPACITY];
    int held_count = 0;
    logic [CW-1:0] comparison_sum = '0;
    bit dropped = 1'b0;

    int send_idle_pct = 25;
    int recv_stall_pct = 79;
    int mismatches = 0;
    int cycle_count = 0;
    int phase_items = 0;

    insertion_sorter_with_comparison_count #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    // insert one element and, on last, queue the sorted array it completes
    task automatic sort_insert(input isc_pkg::req_t r);
        int pos;
        int added;
        int sum;
        isc_pkg::res_t entry;
        if (held_count >= CAPACITY)
        begin
            dropped = 1'b1;
        end
        else
        begin
            pos = 0;
            while (pos < held_count && $signed(held_values[pos]) <= $signed(r.value))
                pos++;
            added = (held_count - pos) + ((pos > 0) ? 1 : 0);
            sum = int'(comparison_sum) + added;
            comparison_sum = (sum > int'(isc_pkg::COUNT_MAX)) ? isc_pkg::COUNT_MAX
                                                              : CW'(sum);
            for (int i = held_count; i > pos; i--)
                held_values[i] = held_values[i-1];
            held_values[pos] = r.value;
            held_count++;
        end
        if (r.last)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                entry.sorted_value = held_values[k];
                entry.comparisons = comparison_sum;
                entry.overflow = dropped;
                entry.final_res = (k == held_count - 1);
                expected_sorted.push_back(entry);
            end
            held_count = 0;
            comparison_sum = '0;
            dropped = 1'b0;
        end
    endtask

    task automatic push_elem(input logic signed [DW-1:0] v, input bit is_last,
                             input bit drain);
        array_elem_t e;
        e.payload.value = v;
        e.payload.last = is_last;
        e.drain_first = drain;
        array_elems.push_back(e);
        phase_items++;
    endtask

    function automatic logic signed [DW-1:0] extreme_value();
        logic signed [DW-1:0] v;
        case ($urandom_range(4))
            0: v = {1'b1, {(DW-1){1'b0}}};
            1: v = {1'b0, {(DW-1){1'b1}}};
            2: v = '1;
            3: v = '0;
            default: v = 1;
        endcase
        return v;
    endfunction

    task automatic push_array(input int len, input bit drain);
        int mode;
        int step;
        logic signed [DW-1:0] base;
        logic signed [DW-1:0] v;
        mode = $urandom_range(4);
        step = $urandom_range(1, 1000);
        base = $signed($urandom) >>> 2;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: v = $signed($urandom);
                1: v = $signed($urandom_range(8)) - 4;
                2: v = base + i * step;
                3: v = base - i * step;
                default: v = extreme_value();
            endcase
            push_elem(v, i == len - 1, drain && i == 0);
        end
    endtask

    task automatic push_random_arrays(input int forced_len);
        int r;
        int len;
        if (forced_len > 0)
            push_array(forced_len, 1'b1);
        while (phase_items < PHASE_ITEMS)
        begin
            r = $urandom_range(99);
            if (r < 60)
                len = $urandom_range(1, 6);
            else if (r < 85)
                len = $urandom_range(7, 20);
            else if (r < 93)
                len = $urandom_range(21, CAPACITY);
            else
                len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            push_array(len, $urandom_range(99) < 15);
        end
        phase_items = 0;
    endtask

    task automatic wait_idle();
        while (array_elems.size() != 0 || req_valid || expected_sorted.size() != 0)
            @(posedge clk);
    endtask

    // driver: present pending requests, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sort_insert(req);
            if (!req_valid || !req_stall)
            begin
                if (array_elems.size() != 0
                    && !(array_elems[0].drain_first && expected_sorted.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= array_elems[0].payload;
                    req_valid <= 1'b1;
                    void'(array_elems.pop_front());
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check accepted results against the oldest expectation
    always @(posedge clk)
    begin
        isc_pkg::res_t want;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_sorted.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %0d",
                        $signed(res.sorted_value)));
                end
                else
                begin
                    want = expected_sorted.pop_front();
                    if (res.sorted_value !== want.sorted_value)
                        report_mismatch($sformatf("sorted_value %0d, expected %0d",
                            $signed(res.sorted_value), $signed(want.sorted_value)));
                    if (res.comparisons !== want.comparisons)
                        report_mismatch($sformatf("comparisons %0d, expected %0d",
                            res.comparisons, want.comparisons));
                    if (res.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %0b, expected %0b",
                            res.overflow, want.overflow));
                    if (res.final_res !== want.final_res)
                        report_mismatch($sformatf("final_res %0b, expected %0b",
                            res.final_res, want.final_res));
                end
            end
            res_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("insertion_sorter_with_comparison_count verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_elem({1'b1, {(DW-1){1'b0}}}, 1'b1, 1'b0);
        push_elem({1'b0, {(DW-1){1'b1}}}, 1'b1, 1'b0);
        push_elem({1'b0, {(DW-1){1'b1}}}, 1'b0, 1'b0);
        push_elem({1'b1, {(DW-1){1'b0}}}, 1'b1, 1'b0);
        push_elem(0, 1'b0, 1'b0);
        push_elem(-1, 1'b0, 1'b0);
        push_elem(1, 1'b1, 1'b0);
        for (int i = 3; i >= -1; i--)
            push_elem(i, i == -1, 1'b0);
        for (int i = -2; i <= 2; i++)
            push_elem(i, i == 2, 1'b0);
        push_elem(7, 1'b0, 1'b1);
        push_elem(7, 1'b0, 1'b0);
        push_elem(-7, 1'b0, 1'b0);
        push_elem(7, 1'b0, 1'b0);
        push_elem(-7, 1'b1, 1'b0);
        push_elem({1'b1, {(DW-1){1'b0}}}, 1'b0, 1'b0);
        push_elem({1'b0, {(DW-1){1'b1}}}, 1'b0, 1'b0);
        push_elem({1'b1, {(DW-1){1'b0}}}, 1'b1, 1'b0);
        phase_items = 0;
        push_random_arrays(CAPACITY + 1);
        wait_idle();

        send_idle_pct = 79;
        recv_stall_pct = 25;
        push_random_arrays(CAPACITY + 4);
        wait_idle();

        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random_arrays(CAPACITY);
        wait_idle();

        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("insertion_sorter_with_comparison_count verification clean");
        else
            $display("insertion_sorter_with_comparison_count verification failed");
        $finish;
    end

endmodule

`default_nettype wire
